// ===== hdl/mi3_pkg.sv =====
// ============================================================================
// mi3_pkg
// Shared widths, constants and cofactor index table for the 3x3 inverse core.
// ============================================================================
package mi3_pkg;

    // Fixed point format of entries and results
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;

    // Exact intermediate widths
    localparam int PROD_W = 2 * DATA_W;           // one entry product
    localparam int COF_W  = PROD_W + 1;           // cofactor, signed
    localparam int DET_W  = COF_W + DATA_W + 2;   // determinant, signed
    localparam int MAG_W  = DET_W - 1;            // |det|
    localparam int SH     = 2 * FRAC_BITS + 1;    // numerator shift (2*|adj| << 2F)
    localparam int NUM_W  = COF_W + SH;           // divider numerator
    localparam int QB     = DATA_W + 1;           // quotient bits kept
    localparam int RND_W  = MAG_W + 1 - 2 * FRAC_BITS;

    // Pipeline: seven front stages, divider setup, QB divider steps, output
    localparam int PRE_STG = 7;
    localparam int NSTG    = PRE_STG + QB + 2;

    localparam logic [DATA_W-1:0] ONE_Q   = DATA_W'(1) << FRAC_BITS;
    localparam logic [DATA_W-1:0] SAT_POS = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_NEG = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [MAG_W:0]    RND_HALF = (MAG_W+1)'(1) << (2 * FRAC_BITS - 1);

    // Result flag positions in tuser
    localparam int USER_SING = 0;
    localparam int USER_SAT  = 1;

    // Cofactor k = m[a]*m[b] - m[c]*m[d], entries row-major
    localparam int COF_IDX [9][4] = '{
        '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
        '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
        '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
    };

endpackage

// ===== hdl/matrix_inverse_3x3_core.sv =====
// ============================================================================
// matrix_inverse_3x3_core
// 3x3 inverse of a signed Q16.16 matrix by adjugate over determinant, with
// rounded, saturated results and a singular fallback to the identity.
// ============================================================================
//  channel  | direction | payload
//  s        | in        | tdata: nine entries r0c0..r2c2, 32 bits each
//  m        | out       | tdata: nine inverse entries; tuser: is_singular, any_saturated
//  cfg      | in        | singular_threshold, write enable + data
//
//  One item per cycle sustained while the output is not held. Results come
//  from the 33-step restoring divider (one quotient bit per stage, nine
//  lanes in parallel) behind the front pipeline stages of products and sums.
//  Synchronous active-low reset clears the valid bits and sets the
//  threshold to 1. The whole pipeline holds while a result waits at the
//  output; nothing is dropped or repeated.
// ============================================================================
module matrix_inverse_3x3_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [31:0]  i_cfg_wdata,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [287:0] i_s_tdata,   // entry_r0c0, r0c1, r0c2, r1c0 .. r2c2, 32b each
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [287:0] o_m_tdata,   // inv_r0c0, r0c1, r0c2, r1c0 .. r2c2, 32b each
    output logic [1:0]   o_m_tuser    // is_singular, any_saturated
);

    localparam int DW = mi3_pkg::DATA_W;
    localparam int QB = mi3_pkg::QB;

    logic                         adv;
    logic [mi3_pkg::NSTG-1:0]     r_vld;
    logic [31:0]                  r_thr;

    logic signed [DW-1:0]         m_in [9];

    // stage 1..7 registers
    logic signed [mi3_pkg::PROD_W-1:0] r_pa [9];
    logic signed [mi3_pkg::PROD_W-1:0] r_pb [9];
    logic signed [DW-1:0]              r_m1 [3];
    logic signed [DW-1:0]              r_m2 [3];
    logic signed [mi3_pkg::COF_W-1:0]  r_cof2 [9];
    logic signed [mi3_pkg::COF_W-1:0]  r_cof3 [9];
    logic signed [mi3_pkg::COF_W-1:0]  r_cof4 [9];
    logic signed [mi3_pkg::COF_W-1:0]  r_cof5 [9];
    logic signed [64:0]                r_pl [3];
    logic signed [64:0]                r_ph [3];
    logic signed [mi3_pkg::DET_W-1:0]  r_t [3];
    logic signed [mi3_pkg::DET_W-1:0]  r_det;
    logic [mi3_pkg::MAG_W-1:0]         r_mag;
    logic                              r_detneg;
    logic [mi3_pkg::COF_W-2:0]         r_aadj [9];
    logic [8:0]                        r_aneg;
    logic [mi3_pkg::NUM_W-1:0]         r_num [9];
    logic [mi3_pkg::DET_W-1:0]         r_d7;
    logic [8:0]                        r_neg7;
    logic                              r_sing7;

    // divider stages 0..QB
    logic [mi3_pkg::DET_W-1:0]         r_dr  [QB+1][9];
    logic [QB-1:0]                     r_dq  [QB+1][9];
    logic [QB-1:0]                     r_dn  [QB][9];
    logic [mi3_pkg::DET_W-1:0]         r_dd  [QB+1];
    logic [8:0]                        r_dng [QB+1];
    logic [8:0]                        r_dov [QB+1];
    logic                              r_dsg [QB+1];

    // output register
    logic [287:0]                      r_odata;
    logic [1:0]                        r_ouser;

    logic [mi3_pkg::MAG_W:0]           rnd_sum;
    logic [mi3_pkg::RND_W-1:0]         rnd;
    logic [287:0]                      n_odata;
    logic [1:0]                        n_ouser;

    // Pipeline moves when the output slot is free or being taken
    assign adv        = !r_vld[mi3_pkg::NSTG-1] || i_m_tready;
    assign o_s_tready = adv;
    assign o_m_tvalid = r_vld[mi3_pkg::NSTG-1];
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_ouser;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_thr <= 32'd1;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            if (adv) begin
                r_vld <= {r_vld[mi3_pkg::NSTG-2:0], i_s_tvalid};
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            m_in[k] = $signed(i_s_tdata[k*DW +: DW]);
        end
    end

    // Singular test on the rounded magnitude
    assign rnd_sum = {1'b0, r_mag} + mi3_pkg::RND_HALF;
    assign rnd     = rnd_sum[mi3_pkg::MAG_W -: mi3_pkg::RND_W];

    // Front stages: products, cofactors, determinant, magnitudes, numerators
    always_ff @(posedge i_clk) begin
        if (adv) begin
            // stage 1: eighteen 32x32 products
            for (int k = 0; k < 9; k++) begin
                r_pa[k] <= m_in[mi3_pkg::COF_IDX[k][0]] * m_in[mi3_pkg::COF_IDX[k][1]];
                r_pb[k] <= m_in[mi3_pkg::COF_IDX[k][2]] * m_in[mi3_pkg::COF_IDX[k][3]];
            end
            for (int i = 0; i < 3; i++) begin
                r_m1[i] <= m_in[i];
                r_m2[i] <= r_m1[i];
            end
            // stage 2: cofactors
            for (int k = 0; k < 9; k++) begin
                r_cof2[k] <= {r_pa[k][mi3_pkg::PROD_W-1], r_pa[k]}
                           - {r_pb[k][mi3_pkg::PROD_W-1], r_pb[k]};
                r_cof3[k] <= r_cof2[k];
                r_cof4[k] <= r_cof3[k];
                r_cof5[k] <= r_cof4[k];
            end
            // stage 3: first-row terms split in low and high partial products
            for (int i = 0; i < 3; i++) begin
                r_pl[i] <= r_m2[i] * $signed({1'b0, r_cof2[3*i][31:0]});
                r_ph[i] <= r_m2[i] * $signed(r_cof2[3*i][mi3_pkg::COF_W-1:32]);
            end
            // stage 4: recombine partials
            for (int i = 0; i < 3; i++) begin
                r_t[i] <= (mi3_pkg::DET_W'(r_ph[i]) <<< 32) + mi3_pkg::DET_W'(r_pl[i]);
            end
            // stage 5: determinant
            r_det <= r_t[0] + r_t[1] + r_t[2];
            // stage 6: magnitudes and signs
            r_detneg <= r_det[mi3_pkg::DET_W-1];
            r_mag    <= r_det[mi3_pkg::DET_W-1] ? mi3_pkg::MAG_W'(-r_det)
                                               : mi3_pkg::MAG_W'(r_det);
            for (int k = 0; k < 9; k++) begin
                r_aneg[k] <= r_cof5[k][mi3_pkg::COF_W-1];
                r_aadj[k] <= r_cof5[k][mi3_pkg::COF_W-1]
                           ? (mi3_pkg::COF_W-1)'(-r_cof5[k])
                           : (mi3_pkg::COF_W-1)'(r_cof5[k]);
            end
            // stage 7: rounded numerators, divisor, singular flag
            for (int k = 0; k < 9; k++) begin
                r_num[k] <= (mi3_pkg::NUM_W'(r_aadj[k]) << mi3_pkg::SH)
                          + mi3_pkg::NUM_W'(r_mag);
            end
            r_d7    <= {r_mag, 1'b0};
            r_neg7  <= r_aneg ^ {9{r_detneg}};
            r_sing7 <= (r_mag == '0) || (rnd < mi3_pkg::RND_W'(r_thr));
            // divider setup: overflow check and starting remainder
            for (int k = 0; k < 9; k++) begin
                r_dov[0][k] <= mi3_pkg::DET_W'(r_num[k] >> QB) >= r_d7;
                r_dr[0][k]  <= mi3_pkg::DET_W'(r_num[k] >> QB);
                r_dn[0][k]  <= r_num[k][QB-1:0];
                r_dq[0][k]  <= '0;
            end
            r_dd[0]  <= r_d7;
            r_dng[0] <= r_neg7;
            r_dsg[0] <= r_sing7;
        end
    end

    // Restoring divider, one quotient bit per stage
    for (genvar j = 1; j <= QB; j++) begin : g_div
        logic [mi3_pkg::DET_W:0] trial [9];
        logic [8:0]              ge;
        always_comb begin
            for (int k = 0; k < 9; k++) begin
                trial[k] = {r_dr[j-1][k], r_dn[j-1][k][QB-1]};
                ge[k]    = trial[k] >= {1'b0, r_dd[j-1]};
            end
        end
        always_ff @(posedge i_clk) begin
            if (adv) begin
                for (int k = 0; k < 9; k++) begin
                    r_dr[j][k] <= ge[k] ? mi3_pkg::DET_W'(trial[k] - {1'b0, r_dd[j-1]})
                                        : mi3_pkg::DET_W'(trial[k]);
                    r_dq[j][k] <= {r_dq[j-1][k][QB-2:0], ge[k]};
                end
                r_dd[j]  <= r_dd[j-1];
                r_dng[j] <= r_dng[j-1];
                r_dov[j] <= r_dov[j-1];
                r_dsg[j] <= r_dsg[j-1];
            end
        end
        if (j < QB) begin : g_shift
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    for (int k = 0; k < 9; k++) begin
                        r_dn[j][k] <= r_dn[j-1][k] << 1;
                    end
                end
            end
        end
    end

    // Sign, saturation and singular override
    always_comb begin
        logic [QB-1:0] q;
        logic          sat;
        n_odata = '0;
        n_ouser = '0;
        for (int k = 0; k < 9; k++) begin
            q = r_dq[QB][k];
            if (r_dng[QB][k]) begin
                sat = r_dov[QB][k] || q[QB-1] || (q[DW-1] && (q[DW-2:0] != '0));
                n_odata[k*DW +: DW] = sat ? mi3_pkg::SAT_NEG : -q[DW-1:0];
            end else begin
                sat = r_dov[QB][k] || q[QB-1] || q[DW-1];
                n_odata[k*DW +: DW] = sat ? mi3_pkg::SAT_POS : q[DW-1:0];
            end
            n_ouser[mi3_pkg::USER_SAT] = n_ouser[mi3_pkg::USER_SAT] | sat;
        end
        if (r_dsg[QB]) begin
            n_odata = '0;
            for (int k = 0; k < 9; k += 4) begin
                n_odata[k*DW +: DW] = mi3_pkg::ONE_Q;
            end
            n_ouser = '0;
            n_ouser[mi3_pkg::USER_SING] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_odata <= n_odata;
            r_ouser <= n_ouser;
        end
    end

`ifndef SYNTHESIS
    // A singular result never reports saturation
    a_sing_nosat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[mi3_pkg::USER_SING] |-> !o_m_tuser[mi3_pkg::USER_SAT])
        else $error("singular result flagged saturated");

    // A singular result carries the identity
    a_sing_ident: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[mi3_pkg::USER_SING] |->
            o_m_tdata[31:0] == mi3_pkg::ONE_Q && o_m_tdata[63:32] == '0 &&
            o_m_tdata[287:256] == mi3_pkg::ONE_Q)
        else $error("singular result is not identity");

    // An empty output slot never blocks the input
    a_no_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty output");
`endif

endmodule
